>>> rtl/lmps_pkg.sv
// Shared types and constants for the LED matrix PWM scanner.
package lmps_pkg;

    // Default matrix geometry in pixels.
    localparam int MATRIX_WIDTH_DEFAULT  = 64;
    localparam int MATRIX_HEIGHT_DEFAULT = 32;

    // Field widths fixed by the interface.
    localparam int PIXEL_INDEX_W = 11;
    localparam int PIXEL_W       = 8;
    localparam int LEVEL_W       = 8;
    localparam int POS_W         = 3;
    localparam int ROW_OUT_W     = 5;
    localparam int CFG_DATA_W    = 8;

    // Pixels per column byte and the most bytes driven in one scan step.
    localparam int BYTE_PIXELS = 8;
    localparam int MAX_BYTES   = 8;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] LEVELS_RESET = 8'd16;
    localparam logic               MODE_RESET   = 1'b0;

    typedef enum logic [0:0]
    {
        CMD_WRITE = 1'b0,
        CMD_SCAN  = 1'b1
    } cmd_t;

    typedef enum logic [0:0]
    {
        CFG_LEVELS = 1'b0,
        CFG_MODE   = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0]
    {
        MODE_ROWS_FIRST   = 1'b0,
        MODE_LEVELS_FIRST = 1'b1
    } scan_mode_t;

endpackage

>>> rtl/led_matrix_pwm_scan.sv
// Top level of the LED matrix PWM scanner: frame store, scan sequencer and output pipeline.
//
// Usage. Items arrive on the item channel (item_valid, item_stall). A write transaction
// (command CMD_WRITE) stores pixel_value at pixel_index and yields no result. A scan
// transaction (command CMD_SCAN) compares the current row of the frame store
// against the current brightness level and yields min(MATRIX_WIDTH/8, 8) result
// transactions on the result channel, highest column byte first; the row and level
// counters advance according to scan_mode when the scan is accepted. Registers are
// to be written through the cfg channel (cfg_ready is always high) while the block is
// idle; the block itself does not enforce this. The first result of a scan passes through
// the sequencer, the read stage and the output register. Throughput: one column byte
// per cycle while the receiver does not stall; the next item is accepted in the cycle
// that issues a scan's last read, so scans run back to back without gaps.
// Reset: counters return to zero, registers to their defaults, and every frame store word
// is marked unwritten at once, so the store reads as zero with no clearing pass.
// When the receiver stalls, the output register holds, the read stage fills behind it,
// and item_stall rises as soon as the sequencer can no longer issue reads.
module led_matrix_pwm_scan #(
    parameter int MATRIX_WIDTH  = lmps_pkg::MATRIX_WIDTH_DEFAULT,
    parameter int MATRIX_HEIGHT = lmps_pkg::MATRIX_HEIGHT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item channel.
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [lmps_pkg::PIXEL_INDEX_W-1:0]  pixel_index,
    input  logic [lmps_pkg::PIXEL_W-1:0]        pixel_value,
    // Result channel.
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lmps_pkg::PIXEL_W-1:0]        column_byte,
    output logic [lmps_pkg::POS_W-1:0]          byte_position,
    output logic [lmps_pkg::ROW_OUT_W-1:0]      row_index,
    output logic [lmps_pkg::LEVEL_W-1:0]        level,
    output logic                                blank_after,
    output logic                                last_byte,
    // Configuration channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  lmps_pkg::cfg_index_t                cfg_index,
    input  logic [lmps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lmps_pkg::*;

    // Geometry. Only the first 2**PIXEL_INDEX_W pixels can ever be written; every pixel
    // beyond them reads as zero, so the store holds no more than that.
    localparam int STORE_SIZE = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int WRITABLE   = 2 ** PIXEL_INDEX_W;
    localparam int MEM_PIX    = (STORE_SIZE < WRITABLE) ? STORE_SIZE : WRITABLE;
    localparam int NWORDS     = (MEM_PIX + BYTE_PIXELS - 1) / BYTE_PIXELS;
    localparam int MIDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SADDR_W    = $clog2(STORE_SIZE) + 1;
    localparam int ROW_W      = (MATRIX_HEIGHT > 1) ? $clog2(MATRIX_HEIGHT) : 1;
    localparam int NBYTES     = (MATRIX_WIDTH / BYTE_PIXELS < MAX_BYTES) ?
                                (MATRIX_WIDTH / BYTE_PIXELS) : MAX_BYTES;
    localparam int WORD_W     = BYTE_PIXELS * PIXEL_W;

    // Frame store: one word holds eight neighbouring pixels. Each word has a written flag;
    // a word never written reads as zero.
    logic [WORD_W-1:0]  mem [NWORDS];
    logic [NWORDS-1:0]  wvalid_reg;

    // Configuration registers and scan counters.
    logic [LEVEL_W-1:0] levels_reg;
    logic               mode_reg;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [LEVEL_W-1:0] level_cnt_reg;

    // Sequencer: the scan step whose bytes are being read out.
    logic               seq_active_reg;
    logic [POS_W-1:0]   seq_pos_reg;
    logic [ROW_W-1:0]   seq_row_reg;
    logic [LEVEL_W-1:0] seq_level_reg;
    logic               seq_blank_reg;
    logic [SADDR_W-1:0] seq_base_reg;

    // Read stage: registered memory data and the byte's tags.
    logic               r_valid_reg;
    logic [WORD_W-1:0]  rd0_reg;
    logic [WORD_W-1:0]  rd1_reg;
    logic               r_use0_reg;
    logic               r_use1_reg;
    logic [2:0]         r_lane_reg;
    logic [POS_W-1:0]   r_pos_reg;
    logic [ROW_W-1:0]   r_row_reg;
    logic [LEVEL_W-1:0] r_level_reg;
    logic               r_blank_reg;

    // Output register.
    logic               o_valid_reg;
    logic [PIXEL_W-1:0] o_col_reg;
    logic [POS_W-1:0]   o_pos_reg;
    logic [ROW_W-1:0]   o_row_reg;
    logic [LEVEL_W-1:0] o_level_reg;
    logic               o_blank_reg;
    logic               o_last_reg;

    // Handshake and pipeline control.
    logic               adv_o;
    logic               adv_r;
    logic               issue;
    logic               seq_last;
    logic               item_acc;
    logic               scan_acc;
    logic               wr_en;
    logic [MIDX_W-1:0]  wr_idx;
    logic [2:0]         wr_lane;

    // Counter update.
    logic [LEVEL_W:0]   lvl_plus;
    logic [LEVEL_W-1:0] lvl_next;
    logic [ROW_W:0]     row_plus;
    logic [ROW_W-1:0]   row_next;
    logic [ROW_W-1:0]   row_cnt_next;
    logic [LEVEL_W-1:0] level_cnt_next;
    logic               blank_next;

    // Read address generation.
    logic [SADDR_W-1:0] rd_addr;
    logic [SADDR_W-1:0] rd_word0;
    logic [SADDR_W-1:0] rd_word1;
    logic [MIDX_W-1:0]  rd_idx0;
    logic [MIDX_W-1:0]  rd_idx1;
    logic               rd_in0;
    logic               rd_in1;

    // Byte extraction and compare.
    logic [2*WORD_W-1:0] pair;
    logic [2*WORD_W-1:0] pair_shifted;
    logic [PIXEL_W-1:0]  col_bits;

    assign cfg_ready = 1'b1;

    // A new item is taken once the sequencer is free or is issuing its final read.
    assign adv_o      = !o_valid_reg || !result_stall;
    assign adv_r      = !r_valid_reg || adv_o;
    assign issue      = seq_active_reg && adv_r;
    assign seq_last   = (seq_pos_reg == '0);
    assign item_stall = seq_active_reg && !(seq_last && adv_r);
    assign item_acc   = item_valid && !item_stall;
    assign scan_acc   = item_acc && (command == CMD_SCAN);
    assign wr_en      = item_acc && (command == CMD_WRITE)
                        && ({21'd0, pixel_index} < 32'(MEM_PIX));
    assign wr_idx     = pixel_index[MIDX_W+2:3];
    assign wr_lane    = pixel_index[2:0];

    // The level wraps to zero when it reaches or passes the configured count.
    always_comb
    begin
        lvl_plus = {1'b0, level_cnt_reg} + 9'd1;
        lvl_next = (lvl_plus >= {1'b0, levels_reg}) ? '0 : lvl_plus[LEVEL_W-1:0];
        row_plus = {1'b0, row_cnt_reg} + (ROW_W+1)'(1);
        row_next = (row_plus >= (ROW_W+1)'(MATRIX_HEIGHT)) ? '0 : row_plus[ROW_W-1:0];
        if (mode_reg == MODE_LEVELS_FIRST)
        begin
            blank_next     = (lvl_next == '0);
            level_cnt_next = lvl_next;
            row_cnt_next   = (lvl_next == '0) ? row_next : row_cnt_reg;
        end
        else
        begin
            blank_next     = 1'b1;
            row_cnt_next   = row_next;
            level_cnt_next = (row_next == '0) ? lvl_next : level_cnt_reg;
        end
    end

    // A group of eight pixels need not sit on a word boundary, so two neighbouring
    // words are read and the wanted bytes picked out afterwards.
    always_comb
    begin
        rd_addr  = seq_base_reg + SADDR_W'({seq_pos_reg, 3'b000});
        rd_word0 = rd_addr >> 3;
        rd_word1 = rd_word0 + SADDR_W'(1);
        rd_idx0  = rd_word0[MIDX_W-1:0];
        rd_idx1  = rd_word1[MIDX_W-1:0];
        rd_in0   = (rd_word0 < SADDR_W'(NWORDS));
        rd_in1   = (rd_word1 < SADDR_W'(NWORDS));
    end

    // Frame store array: byte writes from write items, two reads per scan byte.
    // A write into an unwritten word clears the rest of that word at the same time.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wvalid_reg[wr_idx])
            begin
                mem[wr_idx][{wr_lane, 3'b000} +: PIXEL_W] <= pixel_value;
            end
            else
            begin
                mem[wr_idx] <= WORD_W'(pixel_value) << {wr_lane, 3'b000};
            end
        end
        if (issue)
        begin
            rd0_reg <= mem[rd_idx0];
            rd1_reg <= mem[rd_idx1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (wr_en)
        begin
            wvalid_reg[wr_idx] <= 1'b1;
        end
    end

    // Configuration registers and scan counters. The counters move on at the moment a
    // scan is accepted; the step's own row and level are kept in the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= LEVELS_RESET;
            mode_reg      <= MODE_RESET;
            row_cnt_reg   <= '0;
            level_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LEVELS: levels_reg <= cfg_data;
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                endcase
            end
            if (scan_acc)
            begin
                row_cnt_reg   <= row_cnt_next;
                level_cnt_reg <= level_cnt_next;
            end
        end
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
        end
        else if (scan_acc)
        begin
            seq_active_reg <= 1'b1;
        end
        else if (issue && seq_last)
        begin
            seq_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            seq_pos_reg   <= POS_W'(NBYTES - 1);
            seq_row_reg   <= row_cnt_reg;
            seq_level_reg <= level_cnt_reg;
            seq_blank_reg <= blank_next;
            seq_base_reg  <= SADDR_W'(row_cnt_reg) * SADDR_W'(MATRIX_WIDTH);
        end
        else if (issue)
        begin
            seq_pos_reg <= seq_pos_reg - POS_W'(1);
        end
    end

    // Read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv_r)
        begin
            r_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            r_use0_reg  <= rd_in0 && wvalid_reg[rd_idx0];
            r_use1_reg  <= rd_in1 && wvalid_reg[rd_idx1];
            r_lane_reg  <= rd_addr[2:0];
            r_pos_reg   <= seq_pos_reg;
            r_row_reg   <= seq_row_reg;
            r_level_reg <= seq_level_reg;
            r_blank_reg <= seq_blank_reg;
        end
    end

    // Pick the eight pixels of this byte and compare each with the level.
    always_comb
    begin
        pair = {(r_use1_reg ? rd1_reg : '0), (r_use0_reg ? rd0_reg : '0)};
        pair_shifted = pair >> {r_lane_reg, 3'b000};
        for (int j = 0; j < BYTE_PIXELS; j++)
        begin
            col_bits[j] = (pair_shifted[j*PIXEL_W +: PIXEL_W] > r_level_reg);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv_o)
        begin
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o && r_valid_reg)
        begin
            o_col_reg   <= col_bits;
            o_pos_reg   <= r_pos_reg;
            o_row_reg   <= r_row_reg;
            o_level_reg <= r_level_reg;
            o_blank_reg <= r_blank_reg;
            o_last_reg  <= (r_pos_reg == '0);
        end
    end

    assign result_valid  = o_valid_reg;
    assign column_byte   = o_col_reg;
    assign byte_position = o_pos_reg;
    assign row_index     = ROW_OUT_W'(o_row_reg);
    assign level         = o_level_reg;
    assign blank_after   = o_blank_reg;
    assign last_byte     = o_last_reg;

endmodule

>>> rtl/lmps_checker.sv
// Port-level checks for the LED matrix PWM scanner, bound to its top level.
module lmps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] column_byte,
    input logic [2:0] byte_position,
    input logic [4:0] row_index,
    input logic [7:0] level,
    input logic       blank_after,
    input logic       last_byte
);

    // A stalled result transaction keeps its column byte, position, row, level and last_byte.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(column_byte)
            && $stable(byte_position) && $stable(row_index) && $stable(level)
            && $stable(last_byte))
        else $error("stalled result changed");

    // The final byte of a step is exactly the one at position zero.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_byte == (byte_position == 3'd0)))
        else $error("last_byte disagrees with byte_position");

    // Bytes of one step follow without gaps, counting down, with the same row and level.
    a_step_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_byte |=> result_valid
            && byte_position == 3'($past(byte_position) - 3'd1)
            && row_index == $past(row_index) && level == $past(level)
            && blank_after == $past(blank_after))
        else $error("scan step bytes out of sequence");

endmodule

bind led_matrix_pwm_scan lmps_checker u_lmps_checker (.*);
